// ----- hw/rtl/rlta_pkg.sv -----
// ----------------------------------------------------------------------------
// rlta_pkg
// Shared sizes, request and status codes, and chain types for the run-length
// table with positional lookup.
// ----------------------------------------------------------------------------
package rlta_pkg;

  localparam int MAX_RUNS   = 256;
  localparam int VALUE_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_RUNS);
  localparam int CNT_W      = $clog2(MAX_RUNS + 1);
  localparam int END_W      = 17;
  localparam int POS_W      = 16;
  localparam int DATA_W     = 16;

  localparam logic [END_W-1:0] ITEM_LIMIT = END_W'(65536);

  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  localparam logic [2:0] ST_NEW    = 3'd0;
  localparam logic [2:0] ST_EXTEND = 3'd1;
  localparam logic [2:0] ST_ZERO   = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_HIT    = 3'd4;
  localparam logic [2:0] ST_MISS   = 3'd5;
  localparam logic [2:0] ST_CLEAR  = 3'd6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_REPLY
  } state_t;

  // search token walking the chain, one cell per cycle
  typedef struct packed {
    logic                  valid;
    logic                  done;
    logic [POS_W-1:0]      pos;
    logic [VALUE_BITS-1:0] value;
  } probe_t;

  // broadcast write to the selected cell
  typedef struct packed {
    logic                  val_we;
    logic                  end_we;
    logic [VALUE_BITS-1:0] val;
    logic [END_W-1:0]      end_pos;
  } cell_wr_t;

endpackage

// ----- hw/rtl/rlta_cell.sv -----
// ----------------------------------------------------------------------------
// rlta_cell
// One run of the table: its value and cumulative end position. Passes the
// search token on to the next cell every cycle, marking it on a hit.
// ----------------------------------------------------------------------------
module rlta_cell
  import rlta_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     sel,
  input  cell_wr_t wr,
  input  probe_t   probe_in,
  output probe_t   probe_out
);

  logic [VALUE_BITS-1:0] val_r;
  logic [END_W-1:0]      end_r;
  probe_t                probe_r;
  probe_t                probe_nxt;

  always_ff @(posedge clk) begin
    if (sel && wr.val_we) begin
      val_r <= wr.val;
    end
    if (sel && wr.end_we) begin
      end_r <= wr.end_pos;
    end
  end

  // first cell whose end lies past the position holds it
  always_comb begin
    probe_nxt = probe_in;
    if (probe_in.valid && !probe_in.done && (END_W'(probe_in.pos) < end_r)) begin
      probe_nxt.done  = 1'b1;
      probe_nxt.value = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.valid <= 1'b0;
    end else begin
      probe_r.valid <= probe_nxt.valid;
    end
    probe_r.done  <= probe_nxt.done;
    probe_r.pos   <= probe_nxt.pos;
    probe_r.value <= probe_nxt.value;
  end

  assign probe_out = probe_r;

endmodule

// ----- hw/rtl/run_length_table_append_lookup.sv -----
// ----------------------------------------------------------------------------
// run_length_table_append_lookup
// Run-length table with append, clear and positional lookup over a chain of
// run cells.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ channel (valid/ready), one result item per
// request leaves on the out_ channel (valid/ready) from an output register.
// Append, clear, the unused request code and a lookup past the end of the
// sequence finish in the accept cycle: the result is valid in the cycle after.
// A lookup inside the sequence sends a token down the chain of MAX_RUNS run
// cells, one cell per cycle; its outcome at the chain end is captured in a
// holding register and then loaded into the output register.
// One request is in flight at a time: in_ready is high only while no lookup
// is in progress and the output register is empty or being emptied.
// A stalled receiver holds the result in the output register and in_ready
// stays low until it is taken; a finished lookup waits in a holding register.
// Reset empties the table (no runs, sequence length zero) and drops any
// result or search in progress; the run cells need no clearing.
// ----------------------------------------------------------------------------
module run_length_table_append_lookup
  import rlta_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [DATA_W-1:0] in_value_in,
  input  logic [POS_W-1:0]  in_lookup_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic [DATA_W-1:0] out_value_out,
  output logic [CNT_W-1:0]  out_runs_used
);

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      run_total_r, run_total_nxt;
  logic [END_W-1:0]      item_total_r, item_total_nxt;
  logic [VALUE_BITS-1:0] last_val_r, last_val_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [2:0]            out_status_r, out_status_nxt;
  logic [DATA_W-1:0]     out_value_r, out_value_nxt;
  logic [CNT_W-1:0]      out_runs_r, out_runs_nxt;
  logic                  lk_hit_r, lk_hit_nxt;
  logic [VALUE_BITS-1:0] lk_val_r, lk_val_nxt;

  logic                  out_free;
  logic                  accept;
  logic                  load;
  logic [VALUE_BITS-1:0] val;
  logic [IDX_W-1:0]      wr_idx;
  logic [MAX_RUNS-1:0]   wr_sel;
  cell_wr_t              wr_bus;
  probe_t                head;
  probe_t                chain [MAX_RUNS+1];
  probe_t                tail;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign val      = VALUE_BITS'(in_value_in);
  assign chain[0] = head;
  assign tail     = chain[MAX_RUNS];

  genvar k;
  generate
    for (k = 0; k < MAX_RUNS; k++) begin : g_cell
      assign wr_sel[k] = (wr_idx == IDX_W'(k));
      rlta_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .sel       (wr_sel[k]),
        .wr        (wr_bus),
        .probe_in  (chain[k]),
        .probe_out (chain[k+1])
      );
    end
  endgenerate

  always_comb begin
    state_nxt      = state_r;
    run_total_nxt  = run_total_r;
    item_total_nxt = item_total_r;
    last_val_nxt   = last_val_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_runs_nxt   = out_runs_r;
    lk_hit_nxt     = lk_hit_r;
    lk_val_nxt     = lk_val_r;
    load           = 1'b0;
    wr_idx         = run_total_r[IDX_W-1:0];
    wr_bus         = '0;
    head           = '0;
    head.pos       = in_lookup_index;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          load          = 1'b1;
          out_value_nxt = '0;
          unique case (in_req_type)
            REQ_APPEND: begin
              priority if (val == '0) begin
                out_status_nxt = ST_ZERO;
              end else if (item_total_r >= ITEM_LIMIT) begin
                out_status_nxt = ST_FULL;
              end else if ((run_total_r != '0) && (last_val_r == val)) begin
                // extend the last run
                out_status_nxt = ST_EXTEND;
                item_total_nxt = item_total_r + END_W'(1);
                wr_idx         = IDX_W'(run_total_r - CNT_W'(1));
                wr_bus.end_we  = 1'b1;
                wr_bus.end_pos = item_total_r + END_W'(1);
              end else if (run_total_r == CNT_W'(MAX_RUNS)) begin
                out_status_nxt = ST_FULL;
              end else begin
                out_status_nxt = ST_NEW;
                item_total_nxt = item_total_r + END_W'(1);
                run_total_nxt  = run_total_r + CNT_W'(1);
                last_val_nxt   = val;
                wr_bus.val_we  = 1'b1;
                wr_bus.end_we  = 1'b1;
                wr_bus.val     = val;
                wr_bus.end_pos = item_total_r + END_W'(1);
              end
            end
            REQ_LOOKUP: begin
              if (END_W'(in_lookup_index) < item_total_r) begin
                load       = 1'b0;
                head.valid = 1'b1;
                state_nxt  = S_SEARCH;
              end else begin
                out_status_nxt = ST_MISS;
              end
            end
            REQ_CLEAR: begin
              run_total_nxt  = '0;
              item_total_nxt = '0;
              out_status_nxt = ST_CLEAR;
            end
            default: begin
              out_status_nxt = ST_MISS;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (tail.valid) begin
          lk_hit_nxt = tail.done;
          lk_val_nxt = tail.value;
          state_nxt  = S_REPLY;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          load           = 1'b1;
          out_status_nxt = lk_hit_r ? ST_HIT : ST_MISS;
          out_value_nxt  = lk_hit_r ? DATA_W'(lk_val_r) : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
      out_runs_nxt  = run_total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      run_total_r  <= '0;
      item_total_r <= '0;
      last_val_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      run_total_r  <= run_total_nxt;
      item_total_r <= item_total_nxt;
      last_val_r   <= last_val_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_runs_r   <= out_runs_nxt;
    lk_hit_r     <= lk_hit_nxt;
    lk_val_r     <= lk_val_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_out = out_value_r;
  assign out_runs_used = out_runs_r;

  // a token leaves the chain only while its lookup is searching
  a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |-> (state_r == S_SEARCH))
    else $error("search token left the chain outside a search");

  // an in-range position must be covered by some run
  a_tail_hit: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |-> tail.done)
    else $error("in-range lookup found no run");

  a_runs_bound: assert property (@(posedge clk) disable iff (!rst_n)
    run_total_r <= CNT_W'(MAX_RUNS))
    else $error("run count above table size");

  a_items_bound: assert property (@(posedge clk) disable iff (!rst_n)
    item_total_r <= ITEM_LIMIT)
    else $error("sequence length above limit");

  a_new_run_count: assert property (@(posedge clk) disable iff (!rst_n)
    (load && (state_r == S_IDLE) && (out_status_nxt == ST_NEW))
      |=> (run_total_r == $past(run_total_r) + CNT_W'(1)))
    else $error("new run did not advance the run count");

endmodule

// ----- bench/rle_scoreboard_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rle_scoreboard_pkg
// Shadow run table and reply checking for the run-length table bench. Each
// accepted request updates a private copy of the table and queues the reply
// it should produce; each reply leaving the block is matched to the oldest.
// ----------------------------------------------------------------------------
package rle_scoreboard_pkg;
  import rlta_pkg::*;

  // request code the block does not define
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0]        status;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  runs;
  } rle_reply_t;

  class rle_scoreboard;
    logic [VALUE_BITS-1:0] run_val [MAX_RUNS];
    logic [END_W-1:0]      run_end [MAX_RUNS];
    int unsigned           run_cnt = 0;
    int unsigned           seq_len = 0;
    rle_reply_t            replies_due [$];
    int unsigned           errors = 0;
    int unsigned           checked = 0;
    int unsigned           status_seen [8];

    function logic [2:0] append_value(logic [VALUE_BITS-1:0] v);
      if (v == '0) return ST_ZERO;
      // saturated sequence refuses extends and new runs alike
      if (seq_len >= ITEM_LIMIT) return ST_FULL;
      if (run_cnt > 0 && run_val[run_cnt-1] == v) begin
        seq_len++;
        run_end[run_cnt-1] = END_W'(seq_len);
        return ST_EXTEND;
      end
      if (run_cnt >= MAX_RUNS) return ST_FULL;
      seq_len++;
      run_val[run_cnt] = v;
      run_end[run_cnt] = END_W'(seq_len);
      run_cnt++;
      return ST_NEW;
    endfunction

    function void note_request(logic [1:0] req, logic [DATA_W-1:0] val,
                               logic [POS_W-1:0] pos);
      rle_reply_t r;
      int unsigned k;
      r.value = '0;
      case (req)
        REQ_APPEND: r.status = append_value(val);
        REQ_LOOKUP: begin
          r.status = ST_MISS;
          if (pos < seq_len) begin
            k = 0;
            while (k < run_cnt && r.status != ST_HIT) begin
              if (pos < run_end[k]) begin
                r.status = ST_HIT;
                r.value  = run_val[k];
              end
              k++;
            end
          end
        end
        REQ_CLEAR: begin
          run_cnt  = 0;
          seq_len  = 0;
          r.status = ST_CLEAR;
        end
        default: r.status = ST_MISS;
      endcase
      r.runs = CNT_W'(run_cnt);
      replies_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_reply(logic [2:0] st, logic [DATA_W-1:0] v,
                              logic [CNT_W-1:0] n);
      rle_reply_t e;
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0h value %0h runs %0h",
                 $time, st, v, n);
        return;
      end
      e = replies_due.pop_front();
      checked++;
      status_seen[e.status]++;
      compare_field("status", 32'(e.status), 32'(st));
      compare_field("value_out", 32'(e.value), 32'(v));
      compare_field("runs_used", 32'(e.runs), 32'(n));
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction
  endclass

endpackage

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the run-length table with append, clear and positional lookup.
// Directed requests hit the field extremes and corner cases, then the table
// is filled to its run limit, then a random mix of appends, lookups and
// clears runs with bursty idling on both sides, ending in an unthrottled
// stretch and a short directed tail. Every reply is checked against a
// shadow table kept by the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
  import rlta_pkg::*;
  import rle_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = MAX_RUNS + 40;
  localparam int RANDOM_ITEMS = 350;
  localparam int QUIET_ITEMS  = 60;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_req_type;
  logic [DATA_W-1:0] in_value_in;
  logic [POS_W-1:0]  in_lookup_index;
  logic              out_valid;
  logic              out_ready;
  logic [2:0]        out_status;
  logic [DATA_W-1:0] out_value_out;
  logic [CNT_W-1:0]  out_runs_used;

  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;
  bit          hold_request = 1'b0;
  bit          hold_taken = 1'b0;
  int unsigned cycle_cnt = 0;
  rle_scoreboard sb;

  run_length_table_append_lookup dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_value_in     (in_value_in),
    .in_lookup_index (in_lookup_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_value_out   (out_value_out),
    .out_runs_used   (out_runs_used)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_req_type, in_value_in, in_lookup_index);
      if (out_valid && out_ready) sb.check_reply(out_status, out_value_out, out_runs_used);
    end
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [1:0] req, input logic [DATA_W-1:0] val,
                           input logic [POS_W-1:0] pos);
    int unsigned gap;
    gap = 0;
    if (tx_idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_value_in     <= val;
    in_lookup_index <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering items until every queued reply has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned n;
    int unsigned roll;
    logic [DATA_W-1:0] v;
    logic [POS_W-1:0]  p;

    sb = new();
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_req_type     = REQ_APPEND;
    in_value_in     = '0;
    in_lookup_index = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    // empty table, zero value, field extremes, unused code, clear
    send_item(REQ_LOOKUP, 16'h0000, 16'h0000);
    send_item(REQ_LOOKUP, 16'hFFFF, 16'hFFFF);
    send_item(REQ_APPEND, 16'h0000, 16'hFFFF);
    send_item(REQ_APPEND, 16'hFFFF, 16'h0000);
    send_item(REQ_APPEND, 16'hFFFF, 16'h0000);
    send_item(REQ_APPEND, 16'h0001, 16'h0000);
    send_item(REQ_APPEND, 16'h8000, 16'h0000);
    send_item(REQ_APPEND, 16'h7FFF, 16'h0000);
    send_item(REQ_APPEND, 16'h5555, 16'h0000);
    send_item(REQ_APPEND, 16'hAAAA, 16'h0000);
    send_item(REQ_LOOKUP, 16'h0000, 16'h0000);
    send_item(REQ_LOOKUP, 16'h0000, 16'h0001);
    send_item(REQ_LOOKUP, 16'h0000, 16'h0002);
    send_item(REQ_LOOKUP, 16'h0000, 16'h0006);
    send_item(REQ_LOOKUP, 16'h0000, 16'h0007);
    send_item(REQ_LOOKUP, 16'h0000, 16'hFFFF);
    send_item(REQ_UNUSED, 16'hFFFF, 16'hFFFF);
    send_item(REQ_UNUSED, 16'h0000, 16'h0000);
    send_item(REQ_CLEAR, 16'hFFFF, 16'hFFFF);
    send_item(REQ_LOOKUP, 16'h0000, 16'h0000);
    send_item(REQ_APPEND, 16'h1234, 16'h0000);
    send_item(REQ_LOOKUP, 16'h0000, 16'h0000);
    send_item(REQ_CLEAR, 16'h0000, 16'h0000);

    // fill every run slot, then overflow it
    for (n = 0; n < MAX_RUNS; n++) send_item(REQ_APPEND, DATA_W'(n + 1), POS_W'($urandom));
    send_item(REQ_APPEND, 16'hBEEF, 16'h0000);
    send_item(REQ_APPEND, DATA_W'(MAX_RUNS), 16'h0000);
    send_item(REQ_APPEND, 16'h0000, 16'h0000);
    send_item(REQ_LOOKUP, 16'h0000, 16'h0000);
    send_item(REQ_LOOKUP, 16'h0000, POS_W'(MAX_RUNS - 1));
    send_item(REQ_LOOKUP, 16'h0000, POS_W'(MAX_RUNS));
    send_item(REQ_LOOKUP, 16'h0000, POS_W'(MAX_RUNS + 1));
    send_item(REQ_LOOKUP, 16'h0000, 16'hFFFF);
    for (n = 0; n < 8; n++) begin
      send_item(REQ_LOOKUP, DATA_W'($urandom), POS_W'($urandom_range(0, MAX_RUNS)));
    end
    send_item(REQ_CLEAR, 16'h0000, 16'h0000);

    // random mix, mostly appends of a few values and lookups inside the sequence
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        tx_idle_on = $urandom_range(0, 3) != 0;
        rx_idle_on = $urandom_range(0, 3) != 0;
      end
      // no idling in the last stretch
      if (n >= RANDOM_ITEMS - QUIET_ITEMS) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      if (n == 120) hold_request = 1'b1;
      if (n == 250) wait_drained();
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        send_item(REQ_CLEAR, DATA_W'($urandom), POS_W'($urandom));
      end else if (roll < 4) begin
        send_item(REQ_UNUSED, DATA_W'($urandom), POS_W'($urandom));
      end else if (roll < 55) begin
        case ($urandom_range(0, 9))
          0:       v = '0;
          1, 2:    v = DATA_W'($urandom);
          default: v = DATA_W'($urandom_range(1, 3));
        endcase
        send_item(REQ_APPEND, v, POS_W'($urandom));
      end else begin
        roll = $urandom_range(0, 9);
        if (sb.seq_len != 0 && roll < 8) p = POS_W'($urandom_range(0, sb.seq_len - 1));
        else if (roll == 8) p = POS_W'(sb.seq_len);
        else p = POS_W'($urandom);
        send_item(REQ_LOOKUP, DATA_W'($urandom), p);
      end
    end

    // short directed tail, still unthrottled
    wait_drained();
    send_item(REQ_CLEAR, 16'h0000, 16'h0000);
    send_item(REQ_APPEND, 16'h0077, 16'h0000);
    send_item(REQ_LOOKUP, 16'h0000, 16'h0000);
    send_item(REQ_LOOKUP, 16'h0000, 16'h0001);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("tb: %0d replies checked over corner, full-table, random and tail requests",
             sb.checked);
    $display("tb: %0d hits, %0d misses, %0d full, %0d extends, %0d new runs",
             sb.status_seen[ST_HIT], sb.status_seen[ST_MISS], sb.status_seen[ST_FULL],
             sb.status_seen[ST_EXTEND], sb.status_seen[ST_NEW]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/rlta_pkg.sv
hw/rtl/rlta_cell.sv
hw/rtl/run_length_table_append_lookup.sv
bench/rle_scoreboard_pkg.sv
bench/tb_top.sv
